>>> hw/rtl/ddmu_pkg.sv
// ----------------------------------------------------------------------------
// ddmu_pkg: shared types and constants for the 32-bit divide/modulo unit
// Operation codes, widths and the sequencer control bundle.
// ----------------------------------------------------------------------------
package ddmu_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned CNT_W  = $clog2(DATA_W);

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [OP_W-1:0]   op_t;

  // Operation codes; bit 1 marks the signed operations
  localparam op_t OP_UQUO = 2'd0;
  localparam op_t OP_UREM = 2'd1;
  localparam op_t OP_SQUO = 2'd2;
  localparam op_t OP_SREM = 2'd3;

  // Divide-by-zero quotients
  localparam word_t UQUO_DIV0 = 32'hffff_ffff;
  localparam word_t SQUO_DIV0 = 32'h7fff_ffff;

  // Strobes from the sequencer to the datapath
  typedef struct packed {
    logic load;   // capture the operands of an accepted transaction
    logic prep;   // take magnitudes, clear the partial remainder
    logic step;   // one conditional-subtract iteration
    logic fix;    // apply sign and special cases, fill the output register
  } ctl_t;

endpackage

>>> hw/rtl/int32_divide_modulo_unit.sv
// ----------------------------------------------------------------------------
// int32_divide_modulo_unit: 32-bit unsigned/signed divide and modulo
// Sequence: prepare, 32 divide steps, then a fix-up that loads the output
//   register and waits while an earlier result is still unclaimed.
// A new transaction is accepted only while idle, once the previous one has
//   passed fix-up; the single shared 33-bit subtractor retires one quotient
//   bit per cycle during the divide steps.
// Reset: synchronous active-low rst_n clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module int32_divide_modulo_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] dividend, [63:32] divisor
  input  logic [1:0]  in_tuser,   // [1:0] operation
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] result
);
  import ddmu_pkg::*;

  ctl_t  ctl;
  word_t result;

  // Sequencer: accept one transaction while idle, then step the divider.
  // The output register frees the result side; fix-up waits only when a
  // previous result still sits unclaimed there.
  ddmu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  // Datapath: magnitudes for the signed operations, restoring division on
  // magnitudes, then sign correction and the divide-by-zero substitutions.
  // The most negative value by minus one falls out naturally: the magnitude
  // quotient 2^31 is left unnegated, as both signs are negative, and reads as the most negative value.
  ddmu_datapath u_dp (
    .clk         (clk),
    .ctl         (ctl),
    .in_op       (in_tuser[OP_W-1:0]),
    .in_dividend (in_tdata[DATA_W-1:0]),
    .in_divisor  (in_tdata[2*DATA_W-1:DATA_W]),
    .result      (result)
  );

  assign out_tdata = result;

endmodule

>>> hw/rtl/ddmu_datapath.sv
// ----------------------------------------------------------------------------
// ddmu_datapath: operand registers, shared subtractor and result fix-up
// One restoring shift-and-subtract step per cycle on a remainder/quotient pair.
// ----------------------------------------------------------------------------
module ddmu_datapath (
  input  logic           clk,
  input  ddmu_pkg::ctl_t ctl,
  input  ddmu_pkg::op_t  in_op,
  input  ddmu_pkg::word_t in_dividend,
  input  ddmu_pkg::word_t in_divisor,
  output ddmu_pkg::word_t result
);
  import ddmu_pkg::*;

  op_t   op_r;
  word_t dvd_r;         // raw dividend, kept for the divide-by-zero remainder
  word_t dvs_r;         // raw divisor, then its magnitude
  word_t rem_r;
  word_t quo_r;         // dividend magnitude shifting out, quotient shifting in
  logic  n_neg_r;
  logic  d_neg_r;
  logic  dz_r;
  word_t res_r;

  logic           is_signed;
  word_t          abs_n;
  word_t          abs_d;
  logic [DATA_W:0] shifted;
  logic [DATA_W:0] diff;
  logic           ge;
  word_t          quo_neg;
  word_t          rem_neg;
  word_t          res_nxt;

  assign is_signed = op_r[1];
  assign abs_n     = (is_signed && dvd_r[DATA_W-1]) ? (~dvd_r + 1'b1) : dvd_r;
  assign abs_d     = (is_signed && dvs_r[DATA_W-1]) ? (~dvs_r + 1'b1) : dvs_r;

  // Shared trial subtract: shifted remainder below twice a nonzero divisor
  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = ~diff[DATA_W];

  assign quo_neg = ~quo_r + 1'b1;
  assign rem_neg = ~rem_r + 1'b1;

  always_comb begin
    case (op_r)
      OP_UQUO: begin
        res_nxt = dz_r ? UQUO_DIV0 : quo_r;
      end
      OP_UREM: begin
        res_nxt = dz_r ? dvd_r : rem_r;
      end
      OP_SQUO: begin
        res_nxt = dz_r ? SQUO_DIV0 : ((n_neg_r ^ d_neg_r) ? quo_neg : quo_r);
      end
      OP_SREM: begin
        res_nxt = dz_r ? dvd_r : (n_neg_r ? rem_neg : rem_r);
      end
      default: begin
        res_nxt = quo_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r  <= in_op;
      dvd_r <= in_dividend;
      dvs_r <= in_divisor;
    end
    if (ctl.prep) begin
      n_neg_r <= is_signed & dvd_r[DATA_W-1];
      d_neg_r <= is_signed & dvs_r[DATA_W-1];
      dz_r    <= (dvs_r == '0);
      dvs_r   <= abs_d;
      quo_r   <= abs_n;
      rem_r   <= '0;
    end
    if (ctl.step) begin
      rem_r <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], ge};
    end
    if (ctl.fix) begin
      res_r <= res_nxt;
    end
  end

  assign result = res_r;

endmodule

>>> hw/rtl/ddmu_ctrl.sv
// ----------------------------------------------------------------------------
// ddmu_ctrl: sequencer for the iterative divider
// Walks load, prepare, 32 divide steps and fix-up; owns both handshakes.
// ----------------------------------------------------------------------------
module ddmu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output ddmu_pkg::ctl_t ctl
);
  import ddmu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIX  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = ~out_valid_r | out_tready;

  assign ctl.load = in_tvalid & in_tready;
  assign ctl.prep = (state_r == S_PREP);
  assign ctl.step = (state_r == S_DIV);
  assign ctl.fix  = (state_r == S_FIX) & out_free;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (ctl.load) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cnt_nxt   = CNT_W'(DATA_W - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.fix) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && (cnt_r != '0) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("divide step counter skipped");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && (cnt_r == '0) |=> (state_r == S_FIX))
    else $error("divide loop did not end after last step");

  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> (state_r == S_PREP))
    else $error("accepted transaction did not start preparation");

  a_fix_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fix |=> out_valid_r && (state_r == S_IDLE))
    else $error("fix-up did not present a result");

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for int32_divide_modulo_unit
// Walks a table of directed divide/modulo cases (extremes, divide by zero,
// most negative by minus one, dividend below divisor, every operation), then
// random operands in four flow-control phases. Every result transaction is
// compared with its table entry or a bit-accurate quotient/remainder prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import ddmu_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 408;
  localparam int unsigned DRAIN_CYCLES    = 40;  // longer than the unit's latency
  localparam int unsigned NUM_DIRECTED    = 22;

  // One directed case; the result is typed in only when has_result is set
  typedef struct {
    op_t   op;
    word_t dividend;
    word_t divisor;
    bit    has_result;
    word_t result;
  } div_case_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;   // [31:0] dividend, [63:32] divisor
  logic [1:0]  in_tuser   = '0;   // [1:0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [31:0] result

  word_t       pending_results[$];  // expected results, oldest first
  int          mismatch_count = 0;
  int unsigned send_idle_pct  = 0;  // chance per cycle that the sender holds off
  int unsigned recv_stall_pct = 0;  // chance per cycle that the receiver stalls

  div_case_t directed_cases [NUM_DIRECTED] = '{
    '{OP_UQUO, 32'd100,        32'd7,          1'b1, 32'd14},
    '{OP_UREM, 32'd100,        32'd7,          1'b1, 32'd2},
    '{OP_SQUO, 32'hffff_ff9c,  32'd7,          1'b1, 32'hffff_fff2},
    '{OP_SREM, 32'hffff_ff9c,  32'd7,          1'b1, 32'hffff_fffe},
    '{OP_SQUO, 32'd100,        32'hffff_fff9,  1'b1, 32'hffff_fff2},
    '{OP_SREM, 32'd100,        32'hffff_fff9,  1'b1, 32'd2},
    // divide by zero, both signs of the dividend
    '{OP_UQUO, 32'h1234_5678,  32'd0,          1'b1, UQUO_DIV0},
    '{OP_UREM, 32'h8765_4321,  32'd0,          1'b1, 32'h8765_4321},
    '{OP_SQUO, 32'h8000_0000,  32'd0,          1'b1, SQUO_DIV0},
    '{OP_SQUO, 32'd5,          32'd0,          1'b1, SQUO_DIV0},
    '{OP_SREM, 32'hffff_fffb,  32'd0,          1'b1, 32'hffff_fffb},
    '{OP_UQUO, 32'd0,          32'd0,          1'b1, UQUO_DIV0},
    // most negative by minus one wraps
    '{OP_SQUO, 32'h8000_0000,  32'hffff_ffff,  1'b1, 32'h8000_0000},
    '{OP_SREM, 32'h8000_0000,  32'hffff_ffff,  1'b1, 32'd0},
    // extremes and dividend below divisor
    '{OP_UQUO, 32'hffff_ffff,  32'd1,          1'b1, 32'hffff_ffff},
    '{OP_UREM, 32'hffff_ffff,  32'hffff_ffff,  1'b1, 32'd0},
    '{OP_UQUO, 32'd5,          32'd9,          1'b1, 32'd0},
    '{OP_UREM, 32'd5,          32'd9,          1'b1, 32'd5},
    '{OP_UQUO, 32'h8000_0000,  32'h8000_0000,  1'b1, 32'd1},
    '{OP_UQUO, 32'hffff_ffff,  32'h8000_0001,  1'b0, 32'd0},
    '{OP_SQUO, 32'h7fff_ffff,  32'h8000_0000,  1'b0, 32'd0},
    '{OP_SREM, 32'hffff_fffb,  32'd9,          1'b0, 32'd0}
  };

  int32_divide_modulo_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Quotient or remainder as the unit gives it: truncate toward zero, remainder
  // follows the dividend's sign; x/0 gives a fixed quotient or the dividend.
  function automatic word_t predict_divmod(op_t op, word_t dividend, word_t divisor);
    bit    is_signed;
    bit    neg_n;
    bit    neg_d;
    word_t mag_n;
    word_t mag_d;
    word_t quo;
    word_t rem;
    is_signed = (op == OP_SQUO) || (op == OP_SREM);
    neg_n     = is_signed && dividend[31];
    neg_d     = is_signed && divisor[31];
    mag_n     = neg_n ? word_t'(-dividend) : dividend;
    mag_d     = neg_d ? word_t'(-divisor) : divisor;
    if (divisor == '0) begin
      case (op)
        OP_UQUO: return UQUO_DIV0;
        OP_SQUO: return SQUO_DIV0;
        default: return dividend;
      endcase
    end
    quo = mag_n / mag_d;
    rem = mag_n % mag_d;
    case (op)
      OP_UQUO: return quo;
      OP_UREM: return rem;
      OP_SQUO: return (neg_n ^ neg_d) ? word_t'(-quo) : quo;
      default: return neg_n ? word_t'(-rem) : rem;
    endcase
  endfunction

  // Bias operands toward the corners: zero, all ones, most negative, powers
  // of two, small magnitudes of either sign and random bit lengths.
  function automatic word_t pick_operand();
    word_t v;
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = 32'hffff_ffff;
      2:       v = 32'h8000_0000;
      3:       v = word_t'(1) << $urandom_range(31);
      4:       v = $urandom_range(15);
      5:       v = word_t'(-$urandom_range(16, 1));
      6:       v = $urandom;
      default: begin
        v = $urandom >> $urandom_range(31);
        if ($urandom_range(1) == 1) v = word_t'(-v);
      end
    endcase
    return v;
  endfunction

  // Present one transaction, hold it until accepted, then log its result.
  // An expectation typed into the table wins over the prediction.
  task automatic send_item(op_t op, word_t dividend, word_t divisor,
                           bit has_result, word_t result);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {divisor, dividend};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(has_result ? result
                                         : predict_divmod(op, dividend, divisor));
  endtask

  // Result side: check each transaction against the oldest expectation,
  // then decide whether to stall the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result: unexpected transaction, actual %h", out_tdata);
        mismatch_count <= mismatch_count + 1;
      end else begin
        if (out_tdata !== pending_results[0]) begin
          $error("result: expected %h, actual %h", pending_results[0], out_tdata);
          mismatch_count <= mismatch_count + 1;
        end
        void'(pending_results.pop_front());
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_cases[i]) begin
      send_item(directed_cases[i].op, directed_cases[i].dividend,
                directed_cases[i].divisor, directed_cases[i].has_result,
                directed_cases[i].result);
    end

    // Phases: free flow, idle sender, stalling receiver, both at a low rate
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 67;
        end
        3: begin
          send_idle_pct  = 14;
          recv_stall_pct = 14;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(op_t'($urandom_range(3)), pick_operand(), pick_operand(),
                  1'b0, '0);
      end
    end
    in_tvalid      <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // Drain, then leave room for any stray transaction to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> int32_divide_modulo_unit.f
hw/rtl/ddmu_pkg.sv
hw/rtl/ddmu_datapath.sv
hw/rtl/ddmu_ctrl.sv
hw/rtl/int32_divide_modulo_unit.sv
dv/tb_top.sv
